### hw/rtl/segment_intersection_defines.svh
// Assertion macros for the segment intersection block.
// Needs clk and arst_n in the scope of each use.
`ifndef SEGMENT_INTERSECTION_DEFINES_SVH
`define SEGMENT_INTERSECTION_DEFINES_SVH

// cause in this cycle implies effect in the same cycle
`define SGI_ASSERT_IMPL(lbl, cause, effect, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cause) |-> (effect)) \
		else $error(msg);

// two expressions agree at every edge
`define SGI_ASSERT_SAME(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) 1'b1 |-> ((a) == (b))) \
		else $error(msg);

`endif

### hw/rtl/segint_pkg.sv
// Shared types and constants of the segment intersection block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package segint_pkg;

	localparam int COORD_WIDTH   = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int TOL_W         = 16;
	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] seg1_x0;
		logic signed [COORD_WIDTH-1:0] seg1_x1;
		logic signed [COORD_WIDTH-1:0] seg1_y0;
		logic signed [COORD_WIDTH-1:0] seg1_y1;
		logic signed [COORD_WIDTH-1:0] seg2_x0;
		logic signed [COORD_WIDTH-1:0] seg2_x1;
		logic signed [COORD_WIDTH-1:0] seg2_y0;
		logic signed [COORD_WIDTH-1:0] seg2_y1;
	} seg_in_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] cross_x;
		logic signed [COORD_WIDTH-1:0] cross_y;
		logic                          no_point;
		logic                          crosses;
	} seg_out_t;

	typedef enum logic [2:0] {
		CS_GEN,
		CS_V1,
		CS_V2,
		CS_VV,
		CS_COL,
		CS_PAR,
		CS_H1,
		CS_H2
	} segint_case_t;

endpackage
`default_nettype wire

### hw/rtl/segint_div.sv
// Pipelined signed fixed-point divider: (num * 2^F) / den, truncated, saturated.
// One quotient bit per stage; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module segint_div #(
	parameter int NW  = 33,
	parameter int DW  = 33,
	parameter int QW  = 48,
	parameter int F   = 16,
	parameter int SBW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 feed_valid,
	input  logic signed [NW-1:0] num,
	input  logic signed [DW-1:0] den,
	input  logic [SBW-1:0]       feed_side,
	output logic                 done_valid,
	output logic signed [QW-1:0] quo,
	output logic [SBW-1:0]       done_side
);

	localparam int NNW = NW + F;
	localparam int K   = QW - 1;
	localparam int HW  = NNW - K;
	localparam int EW  = ((HW > DW) ? HW : DW) + 1;

	logic [NW-1:0]  nmag;
	logic [DW-1:0]  dmag;

	logic           v_s0;
	logic [NNW-1:0] n_s0;
	logic [DW-1:0]  d_s0;
	logic           neg_s0, zero_s0;
	logic [SBW-1:0] side_s0;

	logic [EW-1:0]  r0e, de;

	logic           v_sk    [K+1];
	logic [DW-1:0]  r_sk    [K+1];
	logic [K-1:0]   nl_sk   [K+1];
	logic [K-1:0]   q_sk    [K+1];
	logic [DW-1:0]  d_sk    [K+1];
	logic           neg_sk  [K+1];
	logic           zero_sk [K+1];
	logic           ovf_sk  [K+1];
	logic [SBW-1:0] side_sk [K+1];

	logic signed [QW-1:0] qs;

	assign nmag = num[NW-1] ? NW'(-num) : NW'(num);
	assign dmag = den[DW-1] ? DW'(-den) : DW'(den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (adv) begin
			v_s0 <= feed_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s0    <= {nmag, {F{1'b0}}};
			d_s0    <= dmag;
			neg_s0  <= num[NW-1] ^ den[DW-1];
			zero_s0 <= (num == '0);
			side_s0 <= feed_side;
		end
	end

	assign r0e = EW'(n_s0[NNW-1:K]);
	assign de  = EW'(d_s0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sk[0] <= 1'b0;
		end else if (adv) begin
			v_sk[0] <= v_s0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_sk[0]    <= DW'(r0e);
			nl_sk[0]   <= n_s0[K-1:0];
			q_sk[0]    <= '0;
			d_sk[0]    <= d_s0;
			neg_sk[0]  <= neg_s0;
			zero_sk[0] <= zero_s0;
			ovf_sk[0]  <= (r0e >= de);
			side_sk[0] <= side_s0;
		end
	end

	for (genvar j = 1; j <= K; j++) begin : g_step
		logic [DW:0] t;
		logic        ge;

		assign t  = {r_sk[j-1], nl_sk[j-1][K-1]};
		assign ge = (t >= {1'b0, d_sk[j-1]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk[j] <= 1'b0;
			end else if (adv) begin
				v_sk[j] <= v_sk[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				r_sk[j]    <= ge ? DW'(t - {1'b0, d_sk[j-1]}) : DW'(t);
				nl_sk[j]   <= {nl_sk[j-1][K-2:0], 1'b0};
				q_sk[j]    <= {q_sk[j-1][K-2:0], ge};
				d_sk[j]    <= d_sk[j-1];
				neg_sk[j]  <= neg_sk[j-1];
				zero_sk[j] <= zero_sk[j-1];
				ovf_sk[j]  <= ovf_sk[j-1];
				side_sk[j] <= side_sk[j-1];
			end
		end
	end

	assign qs = $signed({1'b0, q_sk[K]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_valid <= 1'b0;
		end else if (adv) begin
			done_valid <= v_sk[K];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			done_side <= side_sk[K];
			if (zero_sk[K]) begin
				quo <= '0;
			end else if (ovf_sk[K]) begin
				quo <= neg_sk[K] ? $signed({1'b1, {K{1'b0}}}) : $signed({1'b0, {K{1'b1}}});
			end else begin
				quo <= neg_sk[K] ? -qs : qs;
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/segint_mul.sv
// Pipelined signed fixed-point multiplier: (a * b) / 2^F, truncated, saturated.
// Split into two partial products; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module segint_mul #(
	parameter int AW  = 48,
	parameter int BW  = 32,
	parameter int F   = 16,
	parameter int OW  = 48,
	parameter int SBW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 feed_valid,
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	input  logic [SBW-1:0]       feed_side,
	output logic                 done_valid,
	output logic signed [OW-1:0] prod,
	output logic [SBW-1:0]       done_side
);

	localparam int HL  = AW / 2;
	localparam int HH  = AW - HL;
	localparam int PW  = AW + BW;
	localparam int QMW = PW - F;

	logic            v_s0, v_s1, v_s2;
	logic [AW-1:0]   am_s0;
	logic [BW-1:0]   bm_s0;
	logic            neg_s0, neg_s1, neg_s2;
	logic [SBW-1:0]  side_s0, side_s1, side_s2;
	logic [HL+BW-1:0] pl_s1;
	logic [HH+BW-1:0] ph_s1;
	logic [PW-1:0]   p_s2;

	logic [QMW-1:0]  q;
	logic            ovf;
	logic signed [OW-1:0] qs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0       <= 1'b0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			done_valid <= 1'b0;
		end else if (adv) begin
			v_s0       <= feed_valid;
			v_s1       <= v_s0;
			v_s2       <= v_s1;
			done_valid <= v_s2;
		end
	end

	assign q   = p_s2[PW-1:F];
	assign ovf = |q[QMW-1:OW-1];
	assign qs  = $signed({1'b0, q[OW-2:0]});

	always_ff @(posedge clk) begin
		if (adv) begin
			am_s0   <= a[AW-1] ? AW'(-a) : AW'(a);
			bm_s0   <= b[BW-1] ? BW'(-b) : BW'(b);
			neg_s0  <= a[AW-1] ^ b[BW-1];
			side_s0 <= feed_side;

			pl_s1   <= (HL+BW)'(am_s0[HL-1:0]) * (HL+BW)'(bm_s0);
			ph_s1   <= (HH+BW)'(am_s0[AW-1:HL]) * (HH+BW)'(bm_s0);
			neg_s1  <= neg_s0;
			side_s1 <= side_s0;

			p_s2    <= (PW'(ph_s1) << HL) + PW'(pl_s1);
			neg_s2  <= neg_s1;
			side_s2 <= side_s1;

			done_side <= side_s2;
			if (ovf) begin
				prod <= neg_s2 ? $signed({1'b1, {(OW-1){1'b0}}})
				               : $signed({1'b0, {(OW-1){1'b1}}});
			end else begin
				prod <= neg_s2 ? -qs : qs;
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/segment_intersection.sv
// Top level of the segment intersection block: slope/intercept pipeline.
// Depends on segint_pkg, segint_div, segint_mul and segment_intersection_defines.svh.
//
//   channel  valid      stall      payload   dir
//   seg      seg_valid  seg_stall  seg       in
//   res      res_valid  res_stall  res       out
//   config   tol_we     -          tol_wdata in
//
// SW is COORD_WIDTH + FRAC_BITS capped at 62. One item enters every cycle unless the
// result is stalled. A stalled result freezes the whole pipeline, so seg_stall follows
// res_stall while res_valid is high. arst_n clears every valid bit and loads tolerance
// with 1.
`timescale 1ns / 1ps
`default_nettype none
`include "segment_intersection_defines.svh"
module segment_intersection #(
	parameter int FRAC_BITS = segint_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                seg_valid,
	output logic                                seg_stall,
	input  segint_pkg::seg_in_t                 seg,
	output logic                                res_valid,
	input  logic                                res_stall,
	output segint_pkg::seg_out_t                res,
	input  logic                                tol_we,
	input  logic [segint_pkg::TOL_W-1:0]        tol_wdata
);
	import segint_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int SW = ((CW + FRAC_BITS) > 62) ? 62 : (CW + FRAC_BITS);

	typedef struct packed {
		seg_in_t item;
		logic    vert1;
		logic    vert2;
	} slope_side_t;

	typedef struct packed {
		seg_in_t             item;
		logic                vert1;
		logic                vert2;
		logic signed [SW-1:0] m1;
	} icpt_side_t;

	typedef struct packed {
		seg_in_t              item;
		segint_case_t         cs;
		logic signed [SW-1:0] msel;
		logic signed [SW-1:0] bsel;
	} xdiv_side_t;

	typedef struct packed {
		seg_in_t              item;
		segint_case_t         cs;
		logic signed [CW-1:0] x;
		logic signed [SW-1:0] bsel;
	} ymul_side_t;

	function automatic logic near_f(input logic signed [SW:0] d, input logic [TOL_W-1:0] t);
		logic signed [SW+1:0] de, te;
		de = (SW+2)'(d);
		te = (SW+2)'($signed({1'b0, t}));
		return (de < te) && (de > -te);
	endfunction

	function automatic logic signed [SW-1:0] sat_sw(input logic signed [SW:0] v);
		if (v[SW] != v[SW-1])
			return v[SW] ? $signed({1'b1, {(SW-1){1'b0}}}) : $signed({1'b0, {(SW-1){1'b1}}});
		return v[SW-1:0];
	endfunction

	function automatic logic signed [CW-1:0] sat_cw(input logic signed [SW:0] v);
		if (!((&v[SW:CW-1]) || !(|v[SW:CW-1])))
			return v[SW] ? $signed({1'b1, {(CW-1){1'b0}}}) : $signed({1'b0, {(CW-1){1'b1}}});
		return v[CW-1:0];
	endfunction

	function automatic logic in_rng(input logic signed [CW-1:0] v,
	                                input logic signed [CW-1:0] p,
	                                input logic signed [CW-1:0] q);
		return ((v >= p) && (v <= q)) || ((v >= q) && (v <= p));
	endfunction

	logic [TOL_W-1:0] tolerance_q;
	logic             adv;

	// input and differences
	logic                 v_s1, v_s2;
	seg_in_t              item_s1, item_s2;
	logic signed [CW:0]   dx1_s2, dy1_s2, dx2_s2, dy2_s2;

	// slopes
	slope_side_t          sl_side_in, sl_side_out;
	logic                 sl2_vert2;
	logic                 sl1_valid, sl2_valid;
	logic signed [SW-1:0] m1_q, m2_q;

	// m*x0 products
	icpt_side_t           ic_side_in, ic_side_out;
	logic                 mx1_valid, mx2_valid;
	logic signed [SW-1:0] mx1_q, mx2_q, m2_lane;

	logic                 v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	seg_in_t              item_s3, item_s4, item_s5, item_s6, item_s7, item_s8;
	logic                 vert1_s3, vert2_s3, vert1_s4, vert2_s4;
	logic signed [SW-1:0] m1_s3, m2_s3, b1_s3, b2_s3;
	logic signed [SW-1:0] m1_s4, m2_s4, b1_s4, b2_s4;
	logic signed [SW:0]   dm_s4, db_s4, nh1_s4, nh2_s4, ng_s4, negm2_s4;

	segint_case_t         cs_c, cs_s5, cs_s6, cs_s7;
	logic signed [SW:0]   num_c, den_c, num_s5, den_s5;
	logic signed [SW-1:0] msel_c, bsel_c, msel_s5, bsel_s5, msel_s6, bsel_s6;

	xdiv_side_t           xd_side_in, xd_side_out;
	logic                 xd_valid;
	logic signed [CW-1:0] xq;
	logic signed [CW-1:0] x_c, x_s6, x_s7;

	ymul_side_t           ym_side_in, ym_side_out;
	logic                 ym_valid;
	logic signed [SW-1:0] my_q;
	logic signed [CW-1:0] y_c, y_s7;
	logic                 none_s7;

	assign adv       = !(res_valid && res_stall);
	assign seg_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= TOL_RESET;
		end else if (tol_we) begin
			tolerance_q <= tol_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= seg_valid;
			v_s2 <= v_s1;
			v_s3 <= mx1_valid && mx2_valid;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= xd_valid;
			v_s7 <= ym_valid;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= seg;
			item_s2 <= item_s1;
			dx1_s2  <= (CW+1)'(item_s1.seg1_x1) - (CW+1)'(item_s1.seg1_x0);
			dy1_s2  <= (CW+1)'(item_s1.seg1_y1) - (CW+1)'(item_s1.seg1_y0);
			dx2_s2  <= (CW+1)'(item_s1.seg2_x1) - (CW+1)'(item_s1.seg2_x0);
			dy2_s2  <= (CW+1)'(item_s1.seg2_y1) - (CW+1)'(item_s1.seg2_y0);
		end
	end

	assign sl_side_in.item  = item_s2;
	assign sl_side_in.vert1 = near_f((SW+1)'(dx1_s2), tolerance_q);
	assign sl_side_in.vert2 = near_f((SW+1)'(dx2_s2), tolerance_q);

	segint_div #(
		.NW(CW+1), .DW(CW+1), .QW(SW), .F(FRAC_BITS), .SBW($bits(slope_side_t))
	) u_slope1 (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.feed_valid(v_s2), .num(dy1_s2), .den(dx1_s2), .feed_side(sl_side_in),
		.done_valid(sl1_valid), .quo(m1_q), .done_side(sl_side_out)
	);

	segint_div #(
		.NW(CW+1), .DW(CW+1), .QW(SW), .F(FRAC_BITS), .SBW(1)
	) u_slope2 (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.feed_valid(v_s2), .num(dy2_s2), .den(dx2_s2), .feed_side(sl_side_in.vert2),
		.done_valid(sl2_valid), .quo(m2_q), .done_side(sl2_vert2)
	);

	assign ic_side_in.item  = sl_side_out.item;
	assign ic_side_in.vert1 = sl_side_out.vert1;
	assign ic_side_in.vert2 = sl2_vert2;
	assign ic_side_in.m1    = m1_q;

	segint_mul #(
		.AW(SW), .BW(CW), .F(FRAC_BITS), .OW(SW), .SBW($bits(icpt_side_t))
	) u_mx1 (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.feed_valid(sl1_valid && sl2_valid), .a(m1_q), .b(sl_side_out.item.seg1_x0),
		.feed_side(ic_side_in),
		.done_valid(mx1_valid), .prod(mx1_q), .done_side(ic_side_out)
	);

	segint_mul #(
		.AW(SW), .BW(CW), .F(FRAC_BITS), .OW(SW), .SBW(SW)
	) u_mx2 (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.feed_valid(sl1_valid && sl2_valid), .a(m2_q), .b(sl_side_out.item.seg2_x0),
		.feed_side(m2_q),
		.done_valid(mx2_valid), .prod(mx2_q), .done_side(m2_lane)
	);

	// intercepts, then differences
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s3  <= ic_side_out.item;
			vert1_s3 <= ic_side_out.vert1;
			vert2_s3 <= ic_side_out.vert2;
			m1_s3    <= ic_side_out.m1;
			m2_s3    <= m2_lane;
			b1_s3    <= sat_sw((SW+1)'(ic_side_out.item.seg1_y0) - (SW+1)'(mx1_q));
			b2_s3    <= sat_sw((SW+1)'(ic_side_out.item.seg2_y0) - (SW+1)'(mx2_q));

			item_s4  <= item_s3;
			vert1_s4 <= vert1_s3;
			vert2_s4 <= vert2_s3;
			m1_s4    <= m1_s3;
			m2_s4    <= m2_s3;
			b1_s4    <= b1_s3;
			b2_s4    <= b2_s3;
			dm_s4    <= (SW+1)'(m1_s3) - (SW+1)'(m2_s3);
			db_s4    <= (SW+1)'(b1_s3) - (SW+1)'(b2_s3);
			ng_s4    <= (SW+1)'(b2_s3) - (SW+1)'(b1_s3);
			nh1_s4   <= (SW+1)'(b2_s3) - (SW+1)'(item_s3.seg1_y0);
			nh2_s4   <= (SW+1)'(item_s3.seg2_y0) - (SW+1)'(b1_s3);
			negm2_s4 <= -(SW+1)'(m2_s3);
		end
	end

	always_comb begin
		priority if (vert1_s4) begin
			cs_c = vert2_s4 ? CS_VV : CS_V1;
		end else if (vert2_s4) begin
			cs_c = CS_V2;
		end else if (near_f(dm_s4, tolerance_q)) begin
			cs_c = near_f(db_s4, tolerance_q) ? CS_COL : CS_PAR;
		end else if (near_f((SW+1)'(m1_s4), tolerance_q)) begin
			cs_c = CS_H1;
		end else if (near_f((SW+1)'(m2_s4), tolerance_q)) begin
			cs_c = CS_H2;
		end else begin
			cs_c = CS_GEN;
		end

		unique case (cs_c)
			CS_H1: begin
				num_c = nh1_s4;
				den_c = negm2_s4;
			end
			CS_H2: begin
				num_c = nh2_s4;
				den_c = (SW+1)'(m1_s4);
			end
			default: begin
				num_c = ng_s4;
				den_c = dm_s4;
			end
		endcase

		if (cs_c == CS_V1) begin
			msel_c = m2_s4;
			bsel_c = b2_s4;
		end else begin
			msel_c = m1_s4;
			bsel_c = b1_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s5 <= item_s4;
			cs_s5   <= cs_c;
			num_s5  <= num_c;
			den_s5  <= den_c;
			msel_s5 <= msel_c;
			bsel_s5 <= bsel_c;
		end
	end

	assign xd_side_in.item = item_s5;
	assign xd_side_in.cs   = cs_s5;
	assign xd_side_in.msel = msel_s5;
	assign xd_side_in.bsel = bsel_s5;

	segint_div #(
		.NW(SW+1), .DW(SW+1), .QW(CW), .F(FRAC_BITS), .SBW($bits(xdiv_side_t))
	) u_xdiv (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.feed_valid(v_s5), .num(num_s5), .den(den_s5), .feed_side(xd_side_in),
		.done_valid(xd_valid), .quo(xq), .done_side(xd_side_out)
	);

	always_comb begin
		unique case (xd_side_out.cs)
			CS_V1, CS_VV:        x_c = xd_side_out.item.seg1_x0;
			CS_V2:               x_c = xd_side_out.item.seg2_x0;
			CS_COL:              x_c = xd_side_out.item.seg1_x1;
			CS_PAR:              x_c = '0;
			CS_H1, CS_H2, CS_GEN: x_c = xq;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s6 <= xd_side_out.item;
			cs_s6   <= xd_side_out.cs;
			msel_s6 <= xd_side_out.msel;
			bsel_s6 <= xd_side_out.bsel;
			x_s6    <= x_c;
		end
	end

	assign ym_side_in.item = item_s6;
	assign ym_side_in.cs   = cs_s6;
	assign ym_side_in.x    = x_s6;
	assign ym_side_in.bsel = bsel_s6;

	segint_mul #(
		.AW(SW), .BW(CW), .F(FRAC_BITS), .OW(SW), .SBW($bits(ymul_side_t))
	) u_ymul (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.feed_valid(v_s6), .a(msel_s6), .b(x_s6), .feed_side(ym_side_in),
		.done_valid(ym_valid), .prod(my_q), .done_side(ym_side_out)
	);

	always_comb begin
		unique case (ym_side_out.cs)
			CS_V1, CS_V2, CS_GEN: y_c = sat_cw((SW+1)'(my_q) + (SW+1)'(ym_side_out.bsel));
			CS_VV, CS_PAR:        y_c = '0;
			CS_COL:               y_c = ym_side_out.item.seg1_y1;
			CS_H1:                y_c = ym_side_out.item.seg1_y0;
			CS_H2:                y_c = ym_side_out.item.seg2_y0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s7 <= ym_side_out.item;
			cs_s7   <= ym_side_out.cs;
			x_s7    <= ym_side_out.x;
			y_s7    <= y_c;
			none_s7 <= (ym_side_out.cs == CS_VV) || (ym_side_out.cs == CS_PAR);

			item_s8      <= item_s7;
			res.cross_x  <= x_s7;
			res.cross_y  <= y_s7;
			res.no_point <= none_s7;
			res.crosses  <= !none_s7 && (cs_s7 != CS_PAR)
			                && in_rng(x_s7, item_s7.seg1_x0, item_s7.seg1_x1)
			                && in_rng(x_s7, item_s7.seg2_x0, item_s7.seg2_x1)
			                && in_rng(y_s7, item_s7.seg1_y0, item_s7.seg1_y1)
			                && in_rng(y_s7, item_s7.seg2_y0, item_s7.seg2_y1);
		end
	end

	assign res_valid = v_s8;

	`SGI_ASSERT_SAME(a_slope_lanes, sl1_valid, sl2_valid, "slope lanes out of step")
	`SGI_ASSERT_SAME(a_mx_lanes, mx1_valid, mx2_valid, "intercept lanes out of step")
	`SGI_ASSERT_IMPL(a_no_cross, res_valid && res.no_point, !res.crosses, "crosses without point")
	`SGI_ASSERT_IMPL(a_item_s8, v_s8 && res.crosses, in_rng(res.cross_x, item_s8.seg1_x0, item_s8.seg1_x1), "crossing outside bounds")

endmodule
`default_nettype wire

### bench/tb_segment_intersection.sv
// Testbench for segment_intersection: directed table, then random segment pairs over
// several tolerance settings and idling modes, each result checked against its row's expected result or a predictor.
// Depends on segint_pkg and the segment_intersection RTL.
`timescale 1ns / 1ps
module tb_segment_intersection;
	import segint_pkg::*;

	localparam int SLOPE_W = 48;
	localparam int ONE = 65536;
	localparam int DRAIN_CYCLES = 120;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct {
		seg_in_t  s;
		bit       known;
		seg_out_t r;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic seg_valid;
	logic seg_stall;
	seg_in_t seg;
	logic res_valid;
	logic res_stall;
	seg_out_t res;
	logic tol_we;
	logic [TOL_W-1:0] tol_wdata;

	longint tol_now;
	seg_out_t crossing_q[$];
	stim_row_t stim_tbl[$];
	int send_pct, stall_pct;
	int mismatches, results_seen, items_sent;
	longint cycles;
	bit hold_go, hold_done;
	int hold_cnt;

	segment_intersection DUT (
		.clk(clk), .arst_n(arst_n),
		.seg_valid(seg_valid), .seg_stall(seg_stall), .seg(seg),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.tol_we(tol_we), .tol_wdata(tol_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] mag(longint a);
		return a < 0 ? 64'(-a) : 64'(a);
	endfunction

	function automatic longint sat_mag(logic [127:0] m, bit neg, int bits);
		logic [127:0] lim;
		lim = 128'd1 << (bits - 1);
		if (neg)
			return m >= lim ? -longint'(lim[63:0]) : -longint'(m[63:0]);
		return m >= lim ? longint'(lim[63:0] - 64'd1) : longint'(m[63:0]);
	endfunction

	function automatic longint sat_s(longint v, int bits);
		return sat_mag({64'd0, mag(v)}, v < 0, bits);
	endfunction

	function automatic longint scaled_quot(longint a, longint b, longint c, int bits);
		bit neg;
		logic [127:0] p, d;
		neg = ((a < 0) != (b < 0)) != (c < 0);
		p = {64'd0, mag(a)} * {64'd0, mag(b)};
		d = {64'd0, mag(c)};
		if (d == 0) begin
			if (p == 0)
				return 0;
			return sat_mag({128{1'b1}}, (a < 0) != (b < 0), bits);
		end
		return sat_mag(p / d, neg, bits);
	endfunction

	function automatic longint qmul(longint a, longint b);
		return scaled_quot(a, b, ONE, SLOPE_W);
	endfunction

	function automatic longint qdiv(longint a, longint b, int bits);
		return scaled_quot(a, ONE, b, bits);
	endfunction

	function automatic bit close(longint a, longint b);
		return mag(a - b) < tol_now;
	endfunction

	function automatic bit between(longint v, longint p, longint q);
		return v >= (p < q ? p : q) && v <= (p < q ? q : p);
	endfunction

	function automatic void line_fit(longint x0, longint x1, longint y0, longint y1,
			output longint m, output longint b);
		m = qdiv(y1 - y0, x1 - x0, SLOPE_W);
		b = sat_s(y0 - qmul(m, x0), SLOPE_W);
	endfunction

	function automatic seg_out_t predict_crossing(seg_in_t s);
		longint ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
		longint m1, b1, m2, b2, x, y;
		bit none, hit;
		seg_out_t r;
		ax0 = s.seg1_x0; ax1 = s.seg1_x1; ay0 = s.seg1_y0; ay1 = s.seg1_y1;
		bx0 = s.seg2_x0; bx1 = s.seg2_x1; by0 = s.seg2_y0; by1 = s.seg2_y1;
		x = 0; y = 0; none = 0; hit = 0;
		if (close(ax0, ax1)) begin
			x = ax0;
			if (close(bx0, bx1)) begin
				none = 1;
			end else begin
				line_fit(bx0, bx1, by0, by1, m2, b2);
				y = sat_s(qmul(m2, x) + b2, COORD_WIDTH);
			end
		end else if (close(bx0, bx1)) begin
			x = bx0;
			line_fit(ax0, ax1, ay0, ay1, m1, b1);
			y = sat_s(qmul(m1, x) + b1, COORD_WIDTH);
		end else begin
			line_fit(ax0, ax1, ay0, ay1, m1, b1);
			line_fit(bx0, bx1, by0, by1, m2, b2);
			if (close(m1, m2)) begin
				if (close(b1, b2)) begin
					x = ax1;
					y = ay1;
				end else begin
					none = 1;
				end
			end else if (close(m1, 0)) begin
				x = qdiv(b2 - ay0, -m2, COORD_WIDTH);
				y = ay0;
			end else if (close(m2, 0)) begin
				x = qdiv(by0 - b1, m1, COORD_WIDTH);
				y = by0;
			end else begin
				x = qdiv(b2 - b1, m1 - m2, COORD_WIDTH);
				y = sat_s(qmul(m1, x) + b1, COORD_WIDTH);
			end
		end
		if (!none)
			hit = between(x, ax0, ax1) && between(x, bx0, bx1) &&
				between(y, ay0, ay1) && between(y, by0, by1);
		r.cross_x = x[31:0];
		r.cross_y = y[31:0];
		r.no_point = none;
		r.crosses = hit;
		return r;
	endfunction

	function automatic int q16(int v);
		return v * ONE;
	endfunction

	function automatic int near_coord();
		return $signed($urandom_range(0, 2 * 200 * ONE)) - 200 * ONE;
	endfunction

	function automatic seg_in_t random_pair();
		seg_in_t s;
		int dx, off;
		s.seg1_x0 = near_coord(); s.seg1_x1 = near_coord();
		s.seg1_y0 = near_coord(); s.seg1_y1 = near_coord();
		s.seg2_x0 = near_coord(); s.seg2_x1 = near_coord();
		s.seg2_y0 = near_coord(); s.seg2_y1 = near_coord();
		dx = $signed($urandom_range(0, 8)) - 4;
		off = ($urandom_range(1) == 1) ? 0 : near_coord();
		case ($urandom_range(9))
			0: s = {$urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom};
			1: s.seg1_x1 = s.seg1_x0 + dx;
			2: s.seg2_x1 = s.seg2_x0 + dx;
			3: begin
				s.seg1_x1 = s.seg1_x0 + dx;
				s.seg2_x1 = s.seg2_x0 - dx;
			end
			4: s.seg1_y1 = s.seg1_y0 + dx;
			5: s.seg2_y1 = s.seg2_y0 + dx;
			6: begin
				s.seg2_x0 = s.seg1_x0 + off; s.seg2_x1 = s.seg1_x1 + off;
				s.seg2_y0 = s.seg1_y0 + off; s.seg2_y1 = s.seg1_y1 + off;
			end
			7: begin
				s.seg1_x0 = $urandom; s.seg2_y1 = $urandom;
			end
			default: ;
		endcase
		return s;
	endfunction

	function automatic void add_row(int ax0, int ax1, int ay0, int ay1,
			int bx0, int bx1, int by0, int by1, bit known = 0,
			int ex = 0, int ey = 0, bit en = 0, bit ec = 0);
		stim_row_t row;
		row.s = {ax0, ax1, ay0, ay1, bx0, bx1, by0, by1};
		row.known = known;
		row.r = {ex, ey, en, ec};
		stim_tbl.push_back(row);
	endfunction

	task automatic send_item(seg_in_t s, bit known, seg_out_t r);
		while ($urandom_range(99) < send_pct) begin
			seg_valid <= 1'b0;
			seg <= {$urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom};
			@(posedge clk);
		end
		seg <= s;
		seg_valid <= 1'b1;
		do @(posedge clk); while (seg_stall);
		crossing_q.push_back(known ? r : predict_crossing(s));
		items_sent++;
	endtask

	task automatic write_tolerance(int v);
		wait (crossing_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		tol_we <= 1'b1;
		tol_wdata <= TOL_W'(v);
		@(posedge clk);
		tol_we <= 1'b0;
		tol_now = v;
	endtask

	always @(posedge clk) begin
		if (hold_go && !hold_done && hold_cnt == 0) begin
			hold_cnt <= 400;
			hold_done <= 1'b1;
			res_stall <= 1'b1;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (crossing_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result x=%h y=%h", res.cross_x, res.cross_y);
			end else if (res.cross_x !== crossing_q[0].cross_x ||
					res.cross_y !== crossing_q[0].cross_y ||
					res.no_point !== crossing_q[0].no_point ||
					res.crosses !== crossing_q[0].crosses) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected x=%h y=%h np=%b cr=%b, got x=%h y=%h np=%b cr=%b",
						crossing_q[0].cross_x, crossing_q[0].cross_y,
						crossing_q[0].no_point, crossing_q[0].crosses,
						res.cross_x, res.cross_y, res.no_point, res.crosses);
				void'(crossing_q.pop_front());
			end else begin
				void'(crossing_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_segment_intersection failed");
			$finish;
		end
	end

	initial begin
		int tols[5];
		int sends[5];
		int stalls[5];
		seg_out_t none_r;
		arst_n = 1'b0;
		seg_valid = 1'b0;
		seg = '0;
		res_stall = 1'b0;
		tol_we = 1'b0;
		tol_wdata = '0;
		tol_now = TOL_RESET;
		send_pct = 0;
		stall_pct = 0;
		mismatches = 0;
		results_seen = 0;
		items_sent = 0;
		cycles = 0;
		hold_go = 0;
		hold_done = 0;
		hold_cnt = 0;
		none_r = '0;
		tols = '{0, 65535, 1000, 1, 0};
		sends = '{0, 64, 0, 27, 10};
		stalls = '{0, 0, 64, 27, 10};
		tols[4] = $urandom_range(65535);

		add_row(0, q16(4), 0, q16(4), 0, q16(4), q16(4), 0);
		add_row(q16(3), q16(3), 0, q16(1), q16(5), q16(5), 0, q16(1),
			1, q16(3), 0, 1, 0);
		add_row(0, q16(4), 0, q16(4), 0, q16(4), q16(1), q16(5), 1, 0, 0, 1, 0);
		add_row(0, q16(2), 0, q16(2), q16(1), q16(3), q16(1), q16(3),
			1, q16(2), q16(2), 0, 1);
		add_row(q16(1), q16(1), q16(-5), q16(5), 0, q16(4), 0, q16(4));
		add_row(0, q16(4), 0, q16(4), q16(2), q16(2), q16(-5), q16(5));
		add_row(0, q16(4), q16(2), q16(2), 0, q16(4), 0, q16(4));
		add_row(0, q16(4), 0, q16(4), q16(-1), q16(7), q16(3), q16(3));
		add_row(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			1, 32'h80000000, 0, 1, 0);
		add_row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			1, 32'h7fffffff, 0, 1, 0);
		add_row(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
		add_row(0, 1, 32'h80000000, 32'h7fffffff, q16(-3), q16(3), 0, 1);
		add_row(q16(-7), q16(9), q16(1), q16(-2), q16(6), q16(-8), q16(4), q16(5));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_tbl[i])
			send_item(stim_tbl[i].s, stim_tbl[i].known, stim_tbl[i].r);
		seg_valid <= 1'b0;

		for (int p = 0; p < 5; p++) begin
			write_tolerance(tols[p]);
			send_pct = sends[p];
			stall_pct = stalls[p];
			for (int n = 0; n < 170; n++) begin
				if (p == 0 && n == 30)
					hold_go = 1;
				send_item(random_pair(), 0, none_r);
			end
			seg_valid <= 1'b0;
		end
		stall_pct = 0;

		wait (crossing_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d segment pairs sent, %0d results checked, tolerance swept 0..65535",
			items_sent, results_seen);
		$display("idling phases covered none, sender, receiver, both; one long output hold");
		if (mismatches == 0 && crossing_q.size() == 0) begin
			$display("tb_segment_intersection passed");
		end else begin
			$display("tb_segment_intersection failed");
		end
		$finish;
	end
endmodule

### files.f
+incdir+hw/rtl
hw/rtl/segint_pkg.sv
hw/rtl/segint_div.sv
hw/rtl/segint_mul.sv
hw/rtl/segment_intersection.sv
bench/tb_segment_intersection.sv
